// File: src/lsbsc_pkg.sv
// Shared types and constants for the LSB audio stego codec.
// No dependencies; imported by lsbsc_step and the top level.
package lsbsc_pkg;

	localparam int unsigned HDR_BITS  = 32;
	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned POS_W     = 36;
	localparam int unsigned LEN_W     = 32;
	localparam int unsigned SMP_W     = 16;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_MODE         = 1'b0,
		REG_EMBED_LENGTH = 1'b1
	} reg_idx_t;

	// Operating mode
	typedef enum logic [0:0] {
		MODE_EXTRACT = 1'b0,
		MODE_EMBED   = 1'b1
	} mode_t;

	// Message tracking state carried from sample to sample
	typedef struct packed {
		logic [POS_W-1:0]     bit_position;
		logic [LEN_W-1:0]     length_reg;
		logic [BYTE_BITS-1:0] byte_shift;
		logic                 finished;
	} msg_state_t;

	// One result beat
	typedef struct packed {
		logic [SMP_W-1:0]     out_sample;
		logic                 byte_taken;
		logic                 header_done;
		logic [LEN_W-1:0]     header_length;
		logic                 byte_valid;
		logic [BYTE_BITS-1:0] out_byte;
		logic                 byte_last;
		logic                 msg_done;
	} result_t;

endpackage

// File: src/lsbsc_step.sv
// Per-sample embed/extract logic: next message state and result beat.
// Purely combinational; depends on lsbsc_pkg.
module lsbsc_step (
	input  lsbsc_pkg::mode_t                    mode,
	input  logic [lsbsc_pkg::LEN_W-1:0]         embed_length,
	input  lsbsc_pkg::msg_state_t               cur,
	input  logic [lsbsc_pkg::SMP_W-1:0]         sample,
	input  logic [lsbsc_pkg::BYTE_BITS-1:0]     msg_byte,
	input  logic                                restart,
	output lsbsc_pkg::msg_state_t               nxt,
	output lsbsc_pkg::result_t                  res
);
	import lsbsc_pkg::*;

	msg_state_t       st;
	logic             lsb;
	logic             embed;
	logic             in_hdr;
	logic [4:0]       hdr_sel;
	logic [2:0]       idx;
	logic [POS_W-1:0] bits_done;
	logic             last_bit;
	logic             bit_out;

	always_comb begin
		// Clear the message state on restart, then handle this sample
		st       = restart ? '0 : cur;
		lsb      = sample[0];
		embed    = (mode == MODE_EMBED);
		in_hdr   = (st.bit_position[POS_W-1:5] == '0);
		hdr_sel  = ~st.bit_position[4:0];
		idx      = st.bit_position[2:0];
		// Bits of payload handled once this one is done: pos - 31
		bits_done = st.bit_position - POS_W'(HDR_BITS - 1);
		last_bit  = (bits_done == {1'b0, st.length_reg, 3'b000});
		bit_out   = 1'b0;

		nxt = st;
		res = '0;
		res.out_sample = sample;

		if (st.finished) begin
			res.msg_done = 1'b1;
		end else begin
			if (in_hdr) begin
				// Length header, MSB first
				if (embed) begin
					if (st.bit_position[4:0] == 5'd0)
						nxt.length_reg = embed_length;
					bit_out = nxt.length_reg[hdr_sel];
					res.out_sample = {sample[SMP_W-1:1], bit_out};
				end else begin
					nxt.length_reg = {st.length_reg[LEN_W-2:0], lsb};
				end
				if (st.bit_position[4:0] == 5'd31) begin
					res.header_done = 1'b1;
					if (nxt.length_reg == '0) begin
						nxt.finished = 1'b1;
						res.msg_done = 1'b1;
					end
				end
			end else begin
				// Message bytes, MSB first
				if (embed) begin
					if (idx == 3'd0) begin
						nxt.byte_shift = msg_byte;
						res.byte_taken = 1'b1;
					end
					bit_out = nxt.byte_shift[~idx];
					res.out_sample = {sample[SMP_W-1:1], bit_out};
				end else begin
					nxt.byte_shift = {st.byte_shift[BYTE_BITS-2:0], lsb};
					if (idx == 3'd7) begin
						res.byte_valid = 1'b1;
						res.out_byte   = nxt.byte_shift;
						res.byte_last  = last_bit;
					end
				end
				if (last_bit) begin
					nxt.finished = 1'b1;
					res.msg_done = 1'b1;
				end
			end
			nxt.bit_position = st.bit_position + POS_W'(1);
		end
		res.header_length = nxt.length_reg;
	end

endmodule

// File: src/lsb_audio_stego_codec_unit.sv
// LSB audio stego codec: embeds or extracts a length-prefixed message in sample LSBs.
// A result beat is registered and appears in the cycle after its sample beat is accepted.
// Throughput: one sample per cycle; input ready whenever the result register is
// empty or is being drained in the same cycle.
// Reset: mode = extract, embed_length = 0, message state cleared, no result held.
// Uses lsbsc_pkg and lsbsc_step.
module lsb_audio_stego_codec_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_index,
	input  logic [lsbsc_pkg::LEN_W-1:0]         cfg_data,
	// sample beats in
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [lsbsc_pkg::SMP_W-1:0]  sample,
	input  logic [lsbsc_pkg::BYTE_BITS-1:0]     msg_byte,
	input  logic                                restart,
	// result beats out
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lsbsc_pkg::SMP_W-1:0]  out_sample,
	output logic                                byte_taken,
	output logic                                header_done,
	output logic [lsbsc_pkg::LEN_W-1:0]         header_length,
	output logic                                byte_valid,
	output logic [lsbsc_pkg::BYTE_BITS-1:0]     out_byte,
	output logic                                byte_last,
	output logic                                msg_done
);
	import lsbsc_pkg::*;

	mode_t            mode_q;
	logic [LEN_W-1:0] embed_length_q;
	msg_state_t       state_q;
	msg_state_t       state_nxt;
	result_t          res_nxt;
	result_t          res_q;
	logic             out_valid_q;
	logic             in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_EXTRACT;
			embed_length_q <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:         mode_q <= mode_t'(cfg_data[0]);
				REG_EMBED_LENGTH: embed_length_q <= cfg_data;
				default:          mode_q <= mode_q;
			endcase
		end
	end

	lsbsc_step u_step (
		.mode         (mode_q),
		.embed_length (embed_length_q),
		.cur          (state_q),
		.sample       (sample),
		.msg_byte     (msg_byte),
		.restart      (restart),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// Advance message state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result payload: load on accept, hold while stalled
	always_ff @(posedge clk) begin
		if (in_fire)
			res_q <= res_nxt;
	end

	assign out_valid     = out_valid_q;
	assign out_sample    = res_q.out_sample;
	assign byte_taken    = res_q.byte_taken;
	assign header_done   = res_q.header_done;
	assign header_length = res_q.header_length;
	assign byte_valid    = res_q.byte_valid;
	assign out_byte      = res_q.out_byte;
	assign byte_last     = res_q.byte_last;
	assign msg_done      = res_q.msg_done;

endmodule
